// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the address range tracker RTL.
// Include with the bare file name; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== hdl/art_pkg.sv =====
// Package for the address range tracker: operation and status codes,
// sequencer states and the compare unit flag struct. No dependencies.
`timescale 1ns / 1ps

package art_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_FIND   = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } art_state_e;

  // Results of the shared compare unit for one candidate entry.
  typedef struct packed {
    logic eq;        // candidate base equals the key
    logic le;        // candidate base is not above the key
    logic gt;        // candidate base is above the current best base
    logic in_range;  // key lies below candidate base plus length
  } cmp_flags_t;

endpackage

// ===== hdl/address_range_tracker_core.sv =====
// Top level of the address range tracker: sequencer, scan registers and
// result registers. Depends on art_pkg, art_table, art_cmp_unit and
// assert_macros.svh.
//
//   channel   | handshake                | payload
//   ----------+--------------------------+----------------------------------
//   command   | start_i high, busy_o low | func_i address_i length_i
//             |                          | pool_id_i
//   result    | valid_o, one cycle       | status_o hit_o found_base_o
//             |                          | found_length_o found_pool_o
//
// After the accepting edge the block reads the table entries in turn, one per
// cycle through its single read port, then passes through the finish state;
// the result strobe follows in the cycle after it. A new word is taken at the
// edge that ends the strobe cycle. After reset the block is busy while it
// clears every entry, one per cycle.
// The receiver cannot stall results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module address_range_tracker_core
  import art_pkg::*;
#(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 48,
  parameter int POOL_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           func_i,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic [ADDR_BITS-1:0] length_i,
  input  logic [POOL_BITS-1:0] pool_id_i,
  output logic                 valid_o,
  output logic [1:0]           status_o,
  output logic                 hit_o,
  output logic [ADDR_BITS-1:0] found_base_o,
  output logic [ADDR_BITS-1:0] found_length_o,
  output logic [POOL_BITS-1:0] found_pool_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = 1 + POOL_BITS + 2 * ADDR_BITS;

  art_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic dup_q, dup_d;
  logic free_vld_q, free_vld_d;
  logic best_vld_q, best_vld_d;
  logic valid_q, valid_d;

  logic [1:0]           func_q, func_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [ADDR_BITS-1:0] len_q, len_d;
  logic [POOL_BITS-1:0] pool_q, pool_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [ADDR_BITS-1:0] best_base_q, best_base_d;
  logic [ADDR_BITS-1:0] best_len_q, best_len_d;
  logic [POOL_BITS-1:0] best_pool_q, best_pool_d;
  status_e              status_q, status_d;
  logic                 hit_q, hit_d;
  logic [ADDR_BITS-1:0] fbase_q, fbase_d;
  logic [ADDR_BITS-1:0] flen_q, flen_d;
  logic [POOL_BITS-1:0] fpool_q, fpool_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;

  logic                 rd_vld;
  logic [POOL_BITS-1:0] rd_pool;
  logic [ADDR_BITS-1:0] rd_len;
  logic [ADDR_BITS-1:0] rd_base;
  logic [CNT_W-1:0]     cnt_prev;
  logic [IDX_W-1:0]     ent_idx;
  logic [ADDR_BITS-1:0] cand_base;
  logic [ADDR_BITS-1:0] cand_len;
  cmp_flags_t           flags;
  logic                 accept;

  art_table #(
    .ENTRIES (ENTRIES),
    .WORD_W  (WORD_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Stored word layout: valid, pool id, length, base.
  assign rd_vld  = rdata[WORD_W-1];
  assign rd_pool = rdata[WORD_W-2 -: POOL_BITS];
  assign rd_len  = rdata[2*ADDR_BITS-1 -: ADDR_BITS];
  assign rd_base = rdata[ADDR_BITS-1:0];

  assign cnt_prev = cnt_q - CNT_W'(1);
  assign ent_idx  = cnt_prev[IDX_W-1:0];

  // The finish cycle reuses the unit for the containment test of the best entry.
  assign cand_base = (state_q == S_FINISH) ? best_base_q : rd_base;
  assign cand_len  = (state_q == S_FINISH) ? best_len_q  : rd_len;

  art_cmp_unit #(
    .ADDR_BITS (ADDR_BITS)
  ) u_cmp (
    .key_i       (addr_q),
    .cand_base_i (cand_base),
    .cand_len_i  (cand_len),
    .best_base_i (best_base_q),
    .flags_o     (flags)
  );

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dup_d       = dup_q;
    free_vld_d  = free_vld_q;
    best_vld_d  = best_vld_q;
    valid_d     = 1'b0;
    func_d      = func_q;
    addr_d      = addr_q;
    len_d       = len_q;
    pool_d      = pool_q;
    free_idx_d  = free_idx_q;
    best_base_d = best_base_q;
    best_len_d  = best_len_q;
    best_pool_d = best_pool_q;
    status_d    = status_q;
    hit_d       = hit_q;
    fbase_d     = fbase_q;
    flen_d      = flen_q;
    fpool_d     = fpool_q;
    we          = 1'b0;
    waddr       = cnt_q[IDX_W-1:0];
    wdata       = '0;
    re          = 1'b0;
    raddr       = cnt_q[IDX_W-1:0];

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ENTRIES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          func_d     = func_i;
          addr_d     = address_i;
          len_d      = length_i;
          pool_d     = pool_id_i;
          dup_d      = 1'b0;
          free_vld_d = 1'b0;
          best_vld_d = 1'b0;
          re         = 1'b1;
          raddr      = '0;
          cnt_d      = CNT_W'(1);
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        // Fetch the next entry while the previous one is checked.
        re    = (cnt_q < CNT_W'(ENTRIES));
        cnt_d = cnt_q + CNT_W'(1);
        if (rd_vld && flags.eq) begin
          dup_d = 1'b1;
          // Bases are unique, so the one match is the entry to drop.
          if (func_q == FUNC_REMOVE) begin
            we    = 1'b1;
            waddr = ent_idx;
          end
        end
        if (!rd_vld && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_idx_d = ent_idx;
        end
        if (rd_vld && flags.le && (!best_vld_q || flags.gt)) begin
          best_vld_d  = 1'b1;
          best_base_d = rd_base;
          best_len_d  = rd_len;
          best_pool_d = rd_pool;
        end
        if (cnt_q == CNT_W'(ENTRIES)) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        status_d = STAT_OK;
        hit_d    = 1'b0;
        fbase_d  = '0;
        flen_d   = '0;
        fpool_d  = '0;
        case (func_q)
          FUNC_ADD: begin
            if (len_q != '0) begin
              if (dup_q) begin
                status_d = STAT_DUP;
              end else if (!free_vld_q) begin
                status_d = STAT_FULL;
              end else begin
                we    = 1'b1;
                waddr = free_idx_q;
                wdata = {1'b1, pool_q, len_q, addr_q};
              end
            end
          end
          FUNC_FIND: begin
            if (best_vld_q && flags.in_range) begin
              hit_d   = 1'b1;
              fbase_d = best_base_q;
              flen_d  = best_len_q;
              fpool_d = best_pool_q;
            end else begin
              status_d = STAT_NOTFOUND;
            end
          end
          default: begin
          end
        endcase
        valid_d = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cnt_q      <= '0;
      dup_q      <= 1'b0;
      free_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      dup_q      <= dup_d;
      free_vld_q <= free_vld_d;
      best_vld_q <= best_vld_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    addr_q      <= addr_d;
    len_q       <= len_d;
    pool_q      <= pool_d;
    free_idx_q  <= free_idx_d;
    best_base_q <= best_base_d;
    best_len_q  <= best_len_d;
    best_pool_q <= best_pool_d;
    status_q    <= status_d;
    hit_q       <= hit_d;
    fbase_q     <= fbase_d;
    flen_q      <= flen_d;
    fpool_q     <= fpool_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign found_base_o   = fbase_q;
  assign found_length_o = flen_q;
  assign found_pool_o   = fpool_q;

  `ASSERT_IMPLIES(a_strobe_idle, clk_i, rst_ni, valid_q, state_q == S_IDLE)
  `ASSERT_NEXT(a_accept_scan, clk_i, rst_ni, accept, state_q == S_SCAN && cnt_q == CNT_W'(1))
  `ASSERT_NEXT(a_finish_strobe, clk_i, rst_ni, state_q == S_FINISH, valid_q)
  `ASSERT_IMPLIES(a_hit_ok, clk_i, rst_ni, valid_q && hit_q, status_q == STAT_OK)
  `ASSERT_IMPLIES(a_miss_zero, clk_i, rst_ni, valid_q && !hit_q, fbase_q == '0 && fpool_q == '0)

endmodule

// ===== hdl/art_table.sv =====
// Entry storage for the address range tracker: one write port and one
// registered read port. Depends on nothing.
`timescale 1ns / 1ps

module art_table #(
  parameter int ENTRIES = 64,
  parameter int WORD_W  = 113
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [WORD_W-1:0]          wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [WORD_W-1:0]          rdata_o
);

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/art_cmp_unit.sv =====
// Shared compare unit: checks one candidate entry against the key and the
// current best base. Depends on art_pkg.
`timescale 1ns / 1ps

module art_cmp_unit
  import art_pkg::*;
#(
  parameter int ADDR_BITS = 48
) (
  input  logic [ADDR_BITS-1:0] key_i,
  input  logic [ADDR_BITS-1:0] cand_base_i,
  input  logic [ADDR_BITS-1:0] cand_len_i,
  input  logic [ADDR_BITS-1:0] best_base_i,
  output cmp_flags_t           flags_o
);

  logic [ADDR_BITS:0] range_end;

  // The end of the range is one bit wider so that it never wraps.
  assign range_end = {1'b0, cand_base_i} + {1'b0, cand_len_i};

  assign flags_o.eq       = (cand_base_i == key_i);
  assign flags_o.le       = (cand_base_i <= key_i);
  assign flags_o.gt       = (cand_base_i > best_base_i);
  assign flags_o.in_range = ({1'b0, key_i} < range_end);

endmodule
